/* design/wrapped_index_value_table_assert.svh */
// Assertion macros for the indexed value table.
`ifndef WRAPPED_INDEX_VALUE_TABLE_ASSERT_SVH
`define WRAPPED_INDEX_VALUE_TABLE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define WIVT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that prop holds in the cycle after cond.
`define WIVT_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

/* design/wivt_pkg.sv */
// Shared constants and types for the indexed value table.
`default_nettype none
package wivt_pkg;
   localparam int KIND_W     = 3;
   localparam int POS_W      = 16;
   localparam int DATA_W     = 32;
   localparam int LEN_W      = 7;
   localparam int STATUS_W   = 3;
   localparam int DIVIDEND_W = POS_W - 1;
   localparam int CAPACITY_DEF = 32;

   localparam logic [KIND_W-1:0] KIND_READ     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_APPEND   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DEL_LAST = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DEL_ALL  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FIND     = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NEG_INDEX = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   localparam logic [LEN_W-1:0]  NO_POS  = '1;
   localparam logic [DATA_W-1:0] NO_DATA = '1;

   typedef enum logic [1:0] {
      RING_HOLD,
      RING_ROTATE,
      RING_DROP,
      RING_APPEND
   } ring_op_type;

   typedef struct packed {
      ring_op_type      op;
      logic [LEN_W-1:0] len;
   } ring_ctl_type;
endpackage
`default_nettype wire

/* design/wivt_cell.sv */
// One table cell: holds an entry and takes its neighbor's word or the tail word.
`default_nettype none
module wivt_cell import wivt_pkg::*; #(
   parameter int INDEX = 0
) (
   input  wire logic              clock,
   input  wire ring_ctl_type      ring_ctl,
   input  wire logic [DATA_W-1:0] neighbor_value,
   input  wire logic [DATA_W-1:0] tail_value,
   output logic      [DATA_W-1:0] value
);
   localparam logic [LEN_W-1:0] IDX      = LEN_W'(INDEX);
   localparam logic [LEN_W-1:0] IDX_NEXT = LEN_W'(INDEX + 1);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (ring_ctl.op)
         RING_ROTATE: begin
            // the ring closes at the last live cell
            if (IDX_NEXT == ring_ctl.len) value_in = tail_value;
            else if (IDX_NEXT < ring_ctl.len) value_in = neighbor_value;
         end
         RING_DROP: begin
            if (IDX_NEXT < ring_ctl.len) value_in = neighbor_value;
         end
         RING_APPEND: begin
            if (IDX == ring_ctl.len) value_in = tail_value;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule
`default_nettype wire

/* design/wivt_mod.sv */
// Bit-serial remainder of the index by the live count.
`default_nettype none
module wivt_mod import wivt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [LEN_W-1:0]      divisor,
   output logic                       done,
   output logic      [LEN_W-1:0]      remainder
);
   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

   typedef enum logic {MOD_IDLE, MOD_RUN} mod_state_type;

   mod_state_type          state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [DIVIDEND_W-1:0]  shift_ff, shift_in;
   logic [LEN_W-1:0]       rem_ff, rem_in;
   logic [LEN_W-1:0]       div_ff, div_in;
   logic                   done_ff, done_in;
   logic [LEN_W:0]         trial;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, shift_ff[DIVIDEND_W-1]};
      unique case (state_ff)
         MOD_IDLE: begin
            if (start) begin
               state_in = MOD_RUN;
               count_in = '0;
               shift_in = dividend;
               rem_in   = '0;
               div_in   = divisor;
            end
         end
         MOD_RUN: begin
            // one quotient bit per cycle, restoring form
            if (trial >= {1'b0, div_ff}) rem_in = LEN_W'(trial - {1'b0, div_ff});
            else rem_in = trial[LEN_W-1:0];
            shift_in = {shift_ff[DIVIDEND_W-2:0], 1'b0};
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_LAST) begin
               state_in = MOD_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = MOD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MOD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      count_ff <= count_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

/* design/wrapped_index_value_table.sv */
// Top level: indexed value table held in a ring of cells, with its sequencer.
//
//  channel  ports                      handshake
//  req      req_kind/position_in/data  start && !busy accepts a word
//  rsp      rsp_* fields               rsp_strobe, one cycle, cannot stall
//
// The live entries sit in cells 0..count-1; a pass rotates them one cell a
// cycle, so entry p reaches cell 0 at step p of the pass and all return home at its end.
// Read/write: decode, the index remainder (one bit a cycle), a handoff, then one scan pass.
// Append: decode only. Delete all: one scan pass. Delete last and find all: a scan and a sweep pass.
// Reset clears the count and the sequencer; the table contents are not cleared.
// Find-all words come out during the second pass, one per match, never stalled.
`default_nettype none
`include "wrapped_index_value_table_assert.svh"
module wrapped_index_value_table import wivt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic        [KIND_W-1:0]   req_kind,
   input  wire logic signed [POS_W-1:0]    req_position_in,
   input  wire logic signed [DATA_W-1:0]   req_data_in,
   output logic                            rsp_strobe,
   output logic signed      [DATA_W-1:0]   rsp_read_data,
   output logic signed      [LEN_W-1:0]    rsp_match_position,
   output logic             [LEN_W-1:0]    rsp_match_total,
   output logic                            rsp_found,
   output logic             [STATUS_W-1:0] rsp_status,
   output logic                            rsp_last
);
   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

   typedef enum logic [2:0] {S_IDLE, S_DECODE, S_MOD, S_SCAN, S_SWEEP} state_type;

   state_type           state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic [LEN_W-1:0]    live_ff, live_in;
   logic [LEN_W-1:0]    step_ff, step_in;
   logic [LEN_W-1:0]    left_ff, left_in;
   logic [LEN_W-1:0]    idx_ff, idx_in;
   logic                hit_ff, hit_in;
   logic [LEN_W-1:0]    n_ff, n_in;
   logic [LEN_W-1:0]    k_ff, k_in;
   logic [DATA_W-1:0]   rdata_ff, rdata_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_W-1:0]   rsp_rd_ff, rsp_rd_in;
   logic [LEN_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [LEN_W-1:0]    rsp_total_ff, rsp_total_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   ring_ctl_type        ring_ctl;
   logic [DATA_W-1:0]   tail_value;
   logic [DATA_W-1:0]   cell_q [CAPACITY];
   logic [DATA_W-1:0]   head;
   logic                match;
   logic                accept;
   logic                at_idx;
   logic                pass_end;
   logic                mod_start;
   logic                mod_done;
   logic [LEN_W-1:0]    mod_rem;
   logic [LEN_W-1:0]    n_now;

   assign accept   = start && (state_ff == S_IDLE);
   assign head     = cell_q[0];
   assign match    = (head == data_ff);
   assign at_idx   = (step_ff == idx_ff);
   assign pass_end = (left_ff == LEN_W'(1));
   assign n_now    = n_ff + LEN_W'(match);
   assign mod_start = (state_ff == S_DECODE) && !pos_ff[POS_W-1] && (live_ff != '0)
                      && ((kind_ff == KIND_READ) || (kind_ff == KIND_WRITE));

   wivt_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (pos_ff[DIVIDEND_W-1:0]),
      .divisor   (live_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i < CAPACITY - 1) begin : g_mid
         wivt_cell #(.INDEX(i)) u_cell (
            .clock          (clock),
            .ring_ctl       (ring_ctl),
            .neighbor_value (cell_q[i+1]),
            .tail_value     (tail_value),
            .value          (cell_q[i])
         );
      end else begin : g_end
         wivt_cell #(.INDEX(i)) u_cell (
            .clock          (clock),
            .ring_ctl       (ring_ctl),
            .neighbor_value (tail_value),
            .tail_value     (tail_value),
            .value          (cell_q[i])
         );
      end
   end

   // ring control for this cycle
   always_comb begin
      ring_ctl.op  = RING_HOLD;
      ring_ctl.len = live_ff;
      tail_value   = head;
      unique case (state_ff)
         S_DECODE: begin
            if ((kind_ff == KIND_APPEND) && (live_ff < CAP_LEN)) begin
               ring_ctl.op = RING_APPEND;
               tail_value  = data_ff;
            end
         end
         S_SCAN: begin
            if ((kind_ff == KIND_DEL_ALL) && match) begin
               ring_ctl.op = RING_DROP;
            end else begin
               ring_ctl.op = RING_ROTATE;
               if ((kind_ff == KIND_WRITE) && at_idx) tail_value = data_ff;
            end
         end
         S_SWEEP: begin
            if ((kind_ff == KIND_DEL_LAST) && at_idx) ring_ctl.op = RING_DROP;
            else ring_ctl.op = RING_ROTATE;
         end
         default: ring_ctl.op = RING_HOLD;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      pos_in   = pos_ff;
      data_in  = data_ff;
      live_in  = live_ff;
      step_in  = step_ff;
      left_in  = left_ff;
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      rdata_in = rdata_ff;

      rsp_strobe_in = 1'b0;
      rsp_rd_in     = '0;
      rsp_pos_in    = NO_POS;
      rsp_total_in  = '0;
      rsp_found_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in  = req_kind;
               pos_in   = req_position_in;
               data_in  = req_data_in;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            step_in = '0;
            left_in = live_ff;
            hit_in  = 1'b0;
            n_in    = '0;
            k_in    = '0;
            unique case (kind_ff)
               KIND_READ, KIND_WRITE: begin
                  if (pos_ff[POS_W-1] || (live_ff == '0)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_rd_in     = (kind_ff == KIND_READ) ? NO_DATA : '0;
                     rsp_status_in = pos_ff[POS_W-1] ? ST_NEG_INDEX : ST_EMPTY;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_MOD;
                  end
               end
               KIND_APPEND: begin
                  rsp_strobe_in = 1'b1;
                  if (live_ff < CAP_LEN) live_in = live_ff + 1'b1;
                  else rsp_status_in = ST_FULL;
                  state_in = S_IDLE;
               end
               KIND_DEL_LAST, KIND_DEL_ALL, KIND_FIND: begin
                  if (live_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_NOT_FOUND;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: state_in = S_IDLE;  // unused kinds: drop silently
            endcase
         end
         S_MOD: begin
            if (mod_done) begin
               idx_in   = mod_rem;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            step_in = step_ff + 1'b1;
            left_in = left_ff - 1'b1;
            if ((kind_ff == KIND_READ) && at_idx) rdata_in = head;
            if ((kind_ff == KIND_DEL_LAST) && match) begin
               hit_in = 1'b1;
               idx_in = step_ff;
            end
            if ((kind_ff == KIND_DEL_ALL) || (kind_ff == KIND_FIND)) n_in = n_now;
            if ((kind_ff == KIND_DEL_ALL) && match) live_in = live_ff - 1'b1;
            if (pass_end) begin
               step_in = '0;
               left_in = live_ff;
               unique case (kind_ff)
                  KIND_READ: begin
                     rsp_strobe_in = 1'b1;
                     rsp_rd_in     = at_idx ? head : rdata_ff;
                     state_in      = S_IDLE;
                  end
                  KIND_DEL_LAST: begin
                     if (hit_ff || match) begin
                        state_in = S_SWEEP;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                        state_in      = S_IDLE;
                     end
                  end
                  KIND_DEL_ALL: begin
                     rsp_strobe_in = 1'b1;
                     if (n_now == '0) begin
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        rsp_total_in = n_now;
                        rsp_found_in = 1'b1;
                     end
                     state_in = S_IDLE;
                  end
                  KIND_FIND: begin
                     if (n_now == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                        state_in      = S_IDLE;
                     end else begin
                        state_in = S_SWEEP;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            step_in = step_ff + 1'b1;
            left_in = left_ff - 1'b1;
            if (kind_ff == KIND_DEL_LAST) begin
               if (at_idx) live_in = live_ff - 1'b1;
               if (pass_end) begin
                  rsp_strobe_in = 1'b1;
                  rsp_pos_in    = idx_ff;
                  rsp_found_in  = 1'b1;
               end
            end else if (match) begin
               // emit one word per match, in index order
               k_in          = k_ff + 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_pos_in    = step_ff;
               rsp_total_in  = n_ff;
               rsp_found_in  = 1'b1;
               rsp_last_in   = ((k_ff + 1'b1) == n_ff);
            end
            if (pass_end) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         live_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      kind_ff       <= kind_in;
      pos_ff        <= pos_in;
      data_ff       <= data_in;
      step_ff       <= step_in;
      left_ff       <= left_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      rdata_ff      <= rdata_in;
      rsp_rd_ff     <= rsp_rd_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_read_data      = rsp_rd_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_match_total    = rsp_total_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last           = rsp_last_ff;

   `WIVT_ASSERT(a_live_bound, live_ff <= CAP_LEN, "live count above capacity")
   `WIVT_ASSERT(a_word_from_busy, !rsp_strobe || $past(busy), "result word without work")
   `WIVT_ASSERT(a_more_while_busy, !(rsp_strobe && !rsp_last) || busy, "open result with idle sequencer")
   `WIVT_ASSERT_NEXT(a_quiet_after_last, rsp_strobe && rsp_last, !rsp_strobe, "word after last")
endmodule
`default_nettype wire
